@@ rtl/r2fft_pkg.sv @@
// ----------------------------------------------------------------------------
// r2fft_pkg
// shared types, register indexes and twiddle table builder for the fft engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package r2fft_pkg;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned WORK_W    = 28;
  localparam int unsigned BIN_W     = 10;
  localparam int unsigned SIZE_W    = 4;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 4;
  localparam int unsigned TW_W      = 17;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd10;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_LOG2 = 1'b0,
    REG_INVERSE   = 1'b1
  } reg_idx_e;

  typedef enum logic {
    ACT_PUSH = 1'b0,
    ACT_READ = 1'b1
  } action_e;

  typedef struct packed {
    logic                       action;
    logic signed [SAMPLE_W-1:0] sample_re;
    logic signed [SAMPLE_W-1:0] sample_im;
  } in_word_t;

  typedef struct packed {
    logic signed [WORK_W-1:0] out_re;
    logic signed [WORK_W-1:0] out_im;
    logic [BIN_W-1:0]         bin_index;
    logic                     out_last;
    logic                     not_ready;
  } out_word_t;

  // q30 to q15 with clamp to [0, 1] and round half up
  function automatic longint q30_to_q15(input longint v);
    longint t;
    begin
      t = v;
      if (t < 0) t = 0;
      if (t > (longint'(1) << 30)) t = longint'(1) << 30;
      return (t + (longint'(1) << 14)) >>> 15;
    end
  endfunction

  // {cos, sin} in q15 of entry idx of a quarter turn split into 2^rw steps
  function automatic logic [2*TW_W-1:0] quarter_cs(input int unsigned idx,
                                                   input int unsigned rw);
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] ts;
    logic [63:0] tc;
    longint      ss;
    longint      sc;
    longint      cq;
    longint      sq;
    begin
      r  = 64'(idx) << (30 - rw);
      x  = (r * HALF_PI_Q30) >> 30;
      x2 = (x * x) >> 30;
      ts = x;
      tc = 64'd1 << 30;
      ss = longint'(x);
      sc = longint'(64'd1 << 30);
      for (int unsigned k = 1; k <= 8; k++) begin
        ts = ((ts * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
        tc = ((tc * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
        if ((k & 1) != 0) begin
          ss = ss - longint'(ts);
          sc = sc - longint'(tc);
        end else begin
          ss = ss + longint'(ts);
          sc = sc + longint'(tc);
        end
      end
      cq = q30_to_q15(sc);
      sq = q30_to_q15(ss);
      return {TW_W'(cq), TW_W'(sq)};
    end
  endfunction

endpackage

`default_nettype wire

@@ rtl/r2fft_cell.sv @@
// ----------------------------------------------------------------------------
// r2fft_cell
// one slot of the butterfly tracking chain, holds a valid flag and addresses
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module r2fft_cell #(
  parameter int unsigned W = 20
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         valid_i,
  input  wire logic [W-1:0] data_i,
  output logic              valid_o,
  output logic [W-1:0]      data_o
);

  logic         valid_q;
  logic [W-1:0] data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_i;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

@@ rtl/r2fft_bfly.sv @@
// ----------------------------------------------------------------------------
// r2fft_bfly
// pipelined butterfly: twiddle rom, complex multiply, round, add and subtract
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module r2fft_bfly #(
  parameter int unsigned RW = 8
) (
  input  wire logic                                   clk_i,
  input  wire logic [RW-1:0]                          tw_idx_i,
  input  wire logic                                   tw_quad_i,
  input  wire logic                                   inv_i,
  input  wire logic [r2fft_pkg::WORK_W-1:0]           a_re_i,
  input  wire logic [r2fft_pkg::WORK_W-1:0]           a_im_i,
  input  wire logic [r2fft_pkg::WORK_W-1:0]           b_re_i,
  input  wire logic [r2fft_pkg::WORK_W-1:0]           b_im_i,
  output logic [r2fft_pkg::WORK_W-1:0]                sum_re_o,
  output logic [r2fft_pkg::WORK_W-1:0]                sum_im_o,
  output logic [r2fft_pkg::WORK_W-1:0]                dif_re_o,
  output logic [r2fft_pkg::WORK_W-1:0]                dif_im_o
);

  localparam int unsigned WW   = r2fft_pkg::WORK_W;
  localparam int unsigned TW   = r2fft_pkg::TW_W;
  localparam int unsigned PW   = WW + TW + 1;
  localparam int unsigned ROMD = 1 << RW;

  logic [2*TW-1:0] rom [ROMD];

  for (genvar i = 0; i < ROMD; i++) begin : g_rom
    localparam logic [2*TW-1:0] ENTRY = r2fft_pkg::quarter_cs(i, RW);
    assign rom[i] = ENTRY;
  end

  logic [2*TW-1:0]       tw_q;
  logic                  quad_q;
  logic                  inv_q;
  logic signed [TW:0]    wr;
  logic signed [TW:0]    wi_pre;
  logic signed [TW:0]    wi;
  logic signed [TW:0]    cos_v;
  logic signed [TW:0]    sin_v;
  logic signed [PW-1:0]  p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic [WW-1:0]         a1_re_q, a1_im_q, a2_re_q, a2_im_q;
  logic signed [PW:0]    acc_re, acc_im;
  logic [WW-1:0]         t_re_q, t_im_q;
  logic [WW-1:0]         dif_re_q, dif_im_q;

  // twiddle fetch at issue
  always_ff @(posedge clk_i) begin
    tw_q   <= rom[tw_idx_i];
    quad_q <= tw_quad_i;
    inv_q  <= inv_i;
  end

  // quarter-turn symmetry and conjugate for the forward direction
  always_comb begin
    cos_v  = $signed({1'b0, tw_q[2*TW-1:TW]});
    sin_v  = $signed({1'b0, tw_q[TW-1:0]});
    wr     = quad_q ? -sin_v : cos_v;
    wi_pre = quad_q ? cos_v : sin_v;
    wi     = inv_q ? wi_pre : -wi_pre;
  end

  always_ff @(posedge clk_i) begin
    p_rr_q  <= PW'(wr * $signed(b_re_i));
    p_ii_q  <= PW'(wi * $signed(b_im_i));
    p_ri_q  <= PW'(wr * $signed(b_im_i));
    p_ir_q  <= PW'(wi * $signed(b_re_i));
    a1_re_q <= a_re_i;
    a1_im_q <= a_im_i;
  end

  // round half up then floor shift by 15
  always_comb begin
    acc_re = (PW+1)'(p_rr_q) - (PW+1)'(p_ii_q) + (PW+1)'(1 << 14);
    acc_im = (PW+1)'(p_ri_q) + (PW+1)'(p_ir_q) + (PW+1)'(1 << 14);
  end

  always_ff @(posedge clk_i) begin
    t_re_q  <= WW'(acc_re >>> 15);
    t_im_q  <= WW'(acc_im >>> 15);
    a2_re_q <= a1_re_q;
    a2_im_q <= a1_im_q;
  end

  assign sum_re_o = a2_re_q + t_re_q;
  assign sum_im_o = a2_im_q + t_im_q;

  always_ff @(posedge clk_i) begin
    dif_re_q <= a2_re_q - t_re_q;
    dif_im_q <= a2_im_q - t_im_q;
  end

  assign dif_re_o = dif_re_q;
  assign dif_im_o = dif_im_q;

endmodule

`default_nettype wire

@@ rtl/radix2_complex_fft_top.sv @@
// ----------------------------------------------------------------------------
// radix2_complex_fft_top
// in-place radix-2 decimation-in-time complex fft with load and read-out
// ----------------------------------------------------------------------------
//  channel   | ports                          | handshake
//  ----------+--------------------------------+---------------------------------
//  in word   | start_i, busy_o, in_i          | taken when start_i && !busy_o
//  result    | res_valid_o, res_o             | one cycle strobe, no back-pressure
//  config    | cfg_we_i, cfg_idx_i, cfg_wdata_i | written when cfg_we_i is high
//
//  pushes are taken while busy_o is low; the last push of a frame raises
//  busy_o for the transform: the single butterfly shares the one memory
//  write port between its sum and difference, and each pass then waits
//  for the tracking chain to drain
//  a read shows its result in the cycle after it is taken; results never stall
//  work memory has no reset; control and config registers take their reset values on rst_ni
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module radix2_complex_fft_top #(
  parameter int unsigned MAX_LOG2 = 10
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  output logic                                     busy_o,
  input  wire r2fft_pkg::in_word_t                 in_i,
  output logic                                     res_valid_o,
  output r2fft_pkg::out_word_t                     res_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [r2fft_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [r2fft_pkg::CFG_W-1:0]         cfg_wdata_i
);

  localparam int unsigned AW    = MAX_LOG2;
  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned KW    = (AW > 1) ? AW - 1 : 1;
  localparam int unsigned LW    = $clog2(MAX_LOG2 + 1);
  localparam int unsigned RW    = (AW > 2) ? AW - 2 : 1;
  localparam int unsigned WW    = r2fft_pkg::WORK_W;
  localparam int unsigned NCELL = 4;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_RUN   = 3'b010,
    S_DRAIN = 3'b100
  } state_e;

  state_e        state_q, state_d;
  logic [LW-1:0] s_q, s_d;          // current pass, 1..l
  logic [KW-1:0] k_q, k_d;          // butterfly count in pass
  logic          ph_q, ph_d;        // issue phase, a butterfly issues while low
  logic [AW-1:0] lc_q, lc_d;        // load count
  logic [AW-1:0] rp_q, rp_d;        // read pointer
  logic          ready_q, ready_d;
  logic [r2fft_pkg::SIZE_W-1:0] size_q, size_d;
  logic          inv_q, inv_d;
  logic          tinv_q, tinv_d;    // inverse flag of the held transform

  logic          ov_q, nr_q, last_q;
  logic [AW-1:0] idx_q;

  // effective size and masks
  logic [LW-1:0] eff_l;
  logic [AW-1:0] nmask;

  always_comb begin
    if (size_q == '0) begin
      eff_l = LW'(1);
    end else if (32'(size_q) > MAX_LOG2) begin
      eff_l = LW'(MAX_LOG2);
    end else begin
      eff_l = LW'(size_q);
    end
    nmask = {AW{1'b1}} >> (LW'(AW) - eff_l);
  end

  logic acc, push, rd;
  assign busy_o = (state_q != S_IDLE);
  assign acc    = start_i & ~busy_o;
  assign push   = acc & (in_i.action == r2fft_pkg::ACT_PUSH);
  assign rd     = acc & (in_i.action == r2fft_pkg::ACT_READ);

  // bit-reversed load address over l bits
  logic [AW-1:0] lc_rev, load_addr;
  always_comb begin
    for (int i = 0; i < AW; i++) begin
      lc_rev[i] = lc_q[AW-1-i];
    end
    load_addr = lc_rev >> (LW'(AW) - eff_l);
  end

  // butterfly addresses and twiddle phase for this pass
  logic [AW-1:0] kx, hm, half, addr_a, addr_b, jj, pp;
  logic [31:0]   phase;
  logic          issue;
  logic          k_last;

  always_comb begin
    kx     = AW'(k_q);
    hm     = {AW{1'b1}} >> (LW'(AW) - (s_q - LW'(1)));
    half   = hm + AW'(1);
    addr_a = ((kx & ~hm) << 1) | (kx & hm);
    addr_b = addr_a | half;
    jj     = kx & hm;
    pp     = jj << (LW'(AW) - s_q);
    phase  = {pp, {(32-AW){1'b0}}};
    k_last = (k_q == KW'(nmask >> 1));
  end

  assign issue = (state_q == S_RUN) && !ph_q;

  // tracking chain: valid and pair addresses follow the butterfly
  logic          cv [NCELL+1];
  logic [2*AW-1:0] cd [NCELL+1];
  logic          pipe_empty;

  assign cv[0] = issue;
  assign cd[0] = {addr_a, addr_b};

  for (genvar g = 0; g < NCELL; g++) begin : g_chain
    r2fft_cell #(.W(2*AW)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(cv[g]),
      .data_i (cd[g]),
      .valid_o(cv[g+1]),
      .data_o (cd[g+1])
    );
  end

  assign pipe_empty = !(cv[1] || cv[2] || cv[3] || cv[4]);

  // work memory, two registered read ports and one write port
  logic [WW-1:0] mem_re [DEPTH];
  logic [WW-1:0] mem_im [DEPTH];
  logic [WW-1:0] ra_re_q, ra_im_q, rb_re_q, rb_im_q;
  logic [AW-1:0] raddr_a, waddr;
  logic [WW-1:0] wdata_re, wdata_im;
  logic          we;
  logic [WW-1:0] sum_re, sum_im, dif_re, dif_im;

  assign raddr_a = busy_o ? addr_a : (rp_q & nmask);

  always_comb begin
    we       = 1'b0;
    waddr    = load_addr;
    wdata_re = WW'(in_i.sample_re);
    wdata_im = WW'(in_i.sample_im);
    priority if (cv[3]) begin
      // top half of the butterfly
      we       = 1'b1;
      waddr    = cd[3][2*AW-1:AW];
      wdata_re = sum_re;
      wdata_im = sum_im;
    end else if (cv[4]) begin
      // bottom half in the cycle after the top half
      we       = 1'b1;
      waddr    = cd[4][AW-1:0];
      wdata_re = dif_re;
      wdata_im = dif_im;
    end else if (push) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_re[waddr] <= wdata_re;
      mem_im[waddr] <= wdata_im;
    end
    ra_re_q <= mem_re[raddr_a];
    ra_im_q <= mem_im[raddr_a];
    rb_re_q <= mem_re[addr_b];
    rb_im_q <= mem_im[addr_b];
  end

  r2fft_bfly #(.RW(RW)) u_bfly (
    .clk_i    (clk_i),
    .tw_idx_i (phase[29 -: RW]),
    .tw_quad_i(phase[30]),
    .inv_i    (tinv_q),
    .a_re_i   (ra_re_q),
    .a_im_i   (ra_im_q),
    .b_re_i   (rb_re_q),
    .b_im_i   (rb_im_q),
    .sum_re_o (sum_re),
    .sum_im_o (sum_im),
    .dif_re_o (dif_re),
    .dif_im_o (dif_im)
  );

  // control
  always_comb begin
    state_d = state_q;
    s_d     = s_q;
    k_d     = k_q;
    ph_d    = ph_q;
    lc_d    = lc_q;
    rp_d    = rp_q;
    ready_d = ready_q;
    size_d  = size_q;
    inv_d   = inv_q;
    tinv_d  = tinv_q;

    unique case (state_q)
      S_IDLE: begin
        if (push) begin
          if (ready_q) begin
            ready_d = 1'b0;
            rp_d    = '0;
          end
          if (lc_q == nmask) begin
            // frame complete, start the passes
            lc_d    = '0;
            rp_d    = '0;
            state_d = S_RUN;
            s_d     = LW'(1);
            k_d     = '0;
            ph_d    = 1'b0;
            tinv_d  = inv_q;
          end else begin
            lc_d = lc_q + AW'(1);
          end
        end else if (rd && ready_q) begin
          if ((rp_q & nmask) == nmask) begin
            ready_d = 1'b0;
            rp_d    = '0;
          end else begin
            rp_d = (rp_q & nmask) + AW'(1);
          end
        end
      end
      S_RUN: begin
        ph_d = ~ph_q;
        if (issue) begin
          if (k_last) begin
            state_d = S_DRAIN;
          end else begin
            k_d = k_q + KW'(1);
          end
        end
      end
      S_DRAIN: begin
        if (pipe_empty) begin
          if (s_q == eff_l) begin
            state_d = S_IDLE;
            ready_d = 1'b1;
            rp_d    = '0;
          end else begin
            state_d = S_RUN;
            s_d     = s_q + LW'(1);
            k_d     = '0;
            ph_d    = 1'b0;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        r2fft_pkg::REG_SIZE_LOG2: begin
          size_d  = cfg_wdata_i;
          lc_d    = '0;
          rp_d    = '0;
          ready_d = 1'b0;
        end
        r2fft_pkg::REG_INVERSE: begin
          inv_d = cfg_wdata_i[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      s_q     <= LW'(1);
      k_q     <= '0;
      ph_q    <= 1'b0;
      lc_q    <= '0;
      rp_q    <= '0;
      ready_q <= 1'b0;
      size_q  <= r2fft_pkg::SIZE_RESET;
      inv_q   <= 1'b0;
      tinv_q  <= 1'b0;
      ov_q    <= 1'b0;
      nr_q    <= 1'b0;
      last_q  <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      s_q     <= s_d;
      k_q     <= k_d;
      ph_q    <= ph_d;
      lc_q    <= lc_d;
      rp_q    <= rp_d;
      ready_q <= ready_d;
      size_q  <= size_d;
      inv_q   <= inv_d;
      tinv_q  <= tinv_d;
      ov_q    <= rd;
      if (rd) begin
        nr_q   <= ~ready_q;
        last_q <= ready_q && ((rp_q & nmask) == nmask);
        idx_q  <= ready_q ? (rp_q & nmask) : '0;
      end
    end
  end

  // read-out word, inverse divides by n with a floor shift
  logic signed [WW-1:0] o_re, o_im;
  always_comb begin
    o_re = $signed(ra_re_q);
    o_im = $signed(ra_im_q);
    if (tinv_q) begin
      o_re = $signed(ra_re_q) >>> eff_l;
      o_im = $signed(ra_im_q) >>> eff_l;
    end
    res_o.out_re    = nr_q ? '0 : o_re;
    res_o.out_im    = nr_q ? '0 : o_im;
    res_o.bin_index = r2fft_pkg::BIN_W'(idx_q);
    res_o.out_last  = last_q;
    res_o.not_ready = nr_q;
  end

  assign res_valid_o = ov_q;

endmodule

`default_nettype wire

@@ test/fft_bin_checker.sv @@
// ----------------------------------------------------------------------------
// fft_bin_checker
// watches the word, result and register channels of the fft engine, keeps
// its own copy of the work memory, predicts every read-out bin and compares
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fft_bin_checker
  import r2fft_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  in_word_t             in_i,
  input  logic                 res_valid_i,
  input  out_word_t            res_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  output int                   fail_count_o,
  output int                   bins_due_o,
  output int                   bins_seen_o
);

  logic signed [WORK_W-1:0] mem_re [1024];
  logic signed [WORK_W-1:0] mem_im [1024];
  logic [SIZE_W-1:0] size_reg;
  logic              inv_reg;
  int unsigned       fill_cnt;
  int unsigned       rd_ptr;
  logic              frame_done;
  out_word_t         bins_due [$];

  assign bins_due_o = bins_due.size();

  function automatic int unsigned used_log2();
    int unsigned l;
    l = size_reg;
    if (l < 1) l = 1;
    if (l > 10) l = 10;
    return l;
  endfunction

  function automatic int unsigned bit_rev(input int unsigned v, input int unsigned bits);
    int unsigned r;
    r = 0;
    for (int unsigned i = 0; i < bits; i++) r = (r << 1) | ((v >> i) & 1);
    return r;
  endfunction

  function automatic longint round_q15(input longint v);
    longint t;
    t = v;
    if (t < 0) t = 0;
    if (t > (64'sd1 <<< 30)) t = 64'sd1 <<< 30;
    return (t + (64'sd1 <<< 14)) >>> 15;
  endfunction

  // q15 twiddle for a 32-bit phase, sign of the angle set by the direction
  task automatic rotor(input logic [31:0] phase, input logic inv,
                       output longint wr, output longint wi);
    longint unsigned ang, ang2, term_s, term_c;
    longint          sin_q, cos_q, cq, sq, ct, st;
    ang    = (longint'(phase[29:0]) * HALF_PI_Q30) >> 30;
    ang2   = (ang * ang) >> 30;
    term_s = ang;
    term_c = 64'd1 << 30;
    sin_q  = longint'(ang);
    cos_q  = 64'sd1 <<< 30;
    for (int unsigned k = 1; k <= 8; k++) begin
      term_s = ((term_s * ang2) >> 30) / longint'((2 * k) * (2 * k + 1));
      term_c = ((term_c * ang2) >> 30) / longint'((2 * k - 1) * (2 * k));
      if (k % 2 == 1) begin
        sin_q -= longint'(term_s);
        cos_q -= longint'(term_c);
      end else begin
        sin_q += longint'(term_s);
        cos_q += longint'(term_c);
      end
    end
    cq = round_q15(cos_q);
    sq = round_q15(sin_q);
    case (phase[31:30])
      2'd0: begin ct = cq;  st = sq;  end
      2'd1: begin ct = -sq; st = cq;  end
      2'd2: begin ct = -cq; st = -sq; end
      default: begin ct = sq; st = -cq; end
    endcase
    wr = ct;
    wi = inv ? st : -st;
  endtask

  task automatic predict_transform(input int unsigned l, input logic inv);
    int unsigned n, half, blk, a, b;
    longint      wr, wi, xr, xi, tr, ti, ar, ai;
    n = 1 << l;
    for (int unsigned s = 1; s <= l; s++) begin
      half = 1 << (s - 1);
      blk  = 1 << s;
      for (int unsigned j = 0; j < half; j++) begin
        rotor(32'(j << (32 - s)), inv, wr, wi);
        for (int unsigned base = 0; base < n; base += blk) begin
          a  = base + j;
          b  = a + half;
          xr = mem_re[b];
          xi = mem_im[b];
          ar = mem_re[a];
          ai = mem_im[a];
          tr = (wr * xr - wi * xi + (64'sd1 <<< 14)) >>> 15;
          ti = (wr * xi + wi * xr + (64'sd1 <<< 14)) >>> 15;
          mem_re[b] = WORK_W'(ar - tr);
          mem_im[b] = WORK_W'(ai - ti);
          mem_re[a] = WORK_W'(ar + tr);
          mem_im[a] = WORK_W'(ai + ti);
        end
      end
    end
    // inverse divides by n with a floor shift
    if (inv) begin
      for (int unsigned i = 0; i < n; i++) begin
        mem_re[i] = mem_re[i] >>> l;
        mem_im[i] = mem_im[i] >>> l;
      end
    end
  endtask

  task automatic take_word(input in_word_t w);
    int unsigned l, n, pos, idx;
    out_word_t   e;
    l = used_log2();
    n = 1 << l;
    if (w.action == ACT_PUSH) begin
      if (frame_done) begin
        frame_done = 1'b0;
        rd_ptr     = 0;
      end
      pos = bit_rev(fill_cnt & (n - 1), l);
      mem_re[pos] = WORK_W'(w.sample_re);
      mem_im[pos] = WORK_W'(w.sample_im);
      fill_cnt++;
      if (fill_cnt >= n) begin
        predict_transform(l, inv_reg);
        fill_cnt   = 0;
        rd_ptr     = 0;
        frame_done = 1'b1;
      end
    end else begin
      e = '0;
      if (!frame_done) begin
        e.not_ready = 1'b1;
      end else begin
        idx         = rd_ptr & (n - 1);
        e.out_re    = mem_re[idx];
        e.out_im    = mem_im[idx];
        e.bin_index = BIN_W'(idx);
        e.out_last  = (idx == n - 1);
        rd_ptr      = idx + 1;
        if (e.out_last) begin
          frame_done = 1'b0;
          rd_ptr     = 0;
        end
      end
      bins_due = {bins_due, e};
    end
  endtask

  task automatic check_bin(input out_word_t got);
    out_word_t e;
    if (bins_due.size() == 0) begin
      fail_count_o++;
      if (fail_count_o <= 10) $display("[%0t] unexpected result word %p", $realtime, got);
      return;
    end
    e = bins_due.pop_front();
    if (got.out_re !== e.out_re || got.out_im !== e.out_im ||
        got.bin_index !== e.bin_index || got.out_last !== e.out_last ||
        got.not_ready !== e.not_ready) begin
      fail_count_o++;
      if (fail_count_o <= 10)
        $display({"[%0t] bin mismatch exp re=%0d im=%0d idx=%0d last=%b nr=%b",
                  " act re=%0d im=%0d idx=%0d last=%b nr=%b"},
                 $realtime, e.out_re, e.out_im, e.bin_index, e.out_last, e.not_ready,
                 got.out_re, got.out_im, got.bin_index, got.out_last, got.not_ready);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_reg     = SIZE_RESET;
      inv_reg      = 1'b0;
      fill_cnt     = 0;
      rd_ptr       = 0;
      frame_done   = 1'b0;
      fail_count_o = 0;
      bins_seen_o  = 0;
      bins_due.delete();
    end else begin
      // results come in the cycle after their read, so check first
      if (res_valid_i) begin
        bins_seen_o++;
        check_bin(res_i);
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_SIZE_LOG2) begin
          size_reg   = cfg_wdata_i;
          fill_cnt   = 0;
          rd_ptr     = 0;
          frame_done = 1'b0;
        end else begin
          inv_reg = cfg_wdata_i[0];
        end
      end
      if (start_i && !busy_i) take_word(in_i);
    end
  end

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// drives frames of samples and bin reads into the fft engine across sizes and
// both directions; the checker predicts every bin and counts mismatches
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import r2fft_pkg::*;

  localparam int WATCHDOG_LIMIT = 60000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start_i = 1'b0;
  logic                 busy_o;
  in_word_t             in_i = '0;
  logic                 res_valid_o;
  out_word_t            res_o;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;

  int fail_count, bins_due, bins_seen;
  int words_sent, frames_run, burst_left, idle_cycles;
  int unsigned cur_log2;

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  radix2_complex_fft_top DUT (
    .clk_i, .rst_ni, .start_i, .busy_o, .in_i, .res_valid_o, .res_o,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  fft_bin_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .in_i, .res_valid_i(res_valid_o),
    .res_i(res_o), .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .fail_count_o(fail_count), .bins_due_o(bins_due), .bins_seen_o(bins_seen)
  );

  // watchdog: any handshake or register write counts as progress
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || res_valid_o || cfg_we_i) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired, bins still due: %0d", bins_due);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // one word; the sender works in bursts with random gaps between them
  task automatic send_word(input action_e act, input logic [15:0] re, input logic [15:0] im);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    start_i          <= 1'b1;
    in_i.action      <= act;
    in_i.sample_re   <= re;
    in_i.sample_im   <= im;
    // busy only moves on a rising edge, so the falling edge shows acceptance
    do @(negedge clk_i); while (busy_o);
    @(posedge clk_i);
    words_sent++;
  endtask

  // registers are written with the engine idle and nothing left to read out
  task automatic write_reg(input reg_idx_e idx, input logic [CFG_W-1:0] val);
    start_i <= 1'b0;
    @(posedge clk_i);
    while (busy_o || bins_due != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_SIZE_LOG2) cur_log2 = (val == 0) ? 1 : (val > 10 ? 10 : val);
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic push_frame(input int count);
    for (int i = 0; i < count; i++) send_word(ACT_PUSH, pick_sample(), pick_sample());
    if (count >= (1 << cur_log2)) frames_run++;
  endtask

  task automatic read_bins(input int count);
    for (int i = 0; i < count; i++) send_word(ACT_READ, 16'($urandom()), 16'($urandom()));
  endtask

  initial begin
    int n, k;
    words_sent = 0;
    frames_run = 0;
    burst_left = 0;
    cur_log2   = 10;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed part
    // reads before any transform answer not ready
    read_bins(2);
    // size 0 behaves as a two point transform, full-scale samples
    write_reg(REG_SIZE_LOG2, 4'd0);
    send_word(ACT_PUSH, 16'h7fff, 16'h8000);
    send_word(ACT_PUSH, 16'h8000, 16'h7fff);
    frames_run++;
    read_bins(3);           // third read is past the last bin
    // inverse two point
    write_reg(REG_INVERSE, 4'b1111);
    write_reg(REG_SIZE_LOG2, 4'd1);
    send_word(ACT_PUSH, 16'h8000, 16'h8000);
    send_word(ACT_PUSH, 16'h7fff, 16'h0001);
    frames_run++;
    read_bins(2);
    // partial frame abandoned by a size write
    write_reg(REG_SIZE_LOG2, 4'd2);
    push_frame(2);
    write_reg(REG_SIZE_LOG2, 4'd3);
    write_reg(REG_INVERSE, 4'b0000);
    push_frame(8);
    read_bins(3);
    // a push while a result is held drops it and starts a new frame
    send_word(ACT_PUSH, 16'h7fff, 16'h7fff);
    read_bins(1);

    // ---- random frames, mostly small sizes
    while (words_sent < 220) begin
      k = $urandom_range(0, 9);
      write_reg(REG_INVERSE, 4'($urandom()));
      write_reg(REG_SIZE_LOG2, k < 8 ? 4'($urandom_range(1, 5)) : 4'($urandom_range(0, 7)));
      n = 1 << cur_log2;
      if ($urandom_range(0, 4) == 0) read_bins($urandom_range(1, 2));
      if ($urandom_range(0, 5) == 0) begin
        // broken sequence: short frame or read-out cut by a push
        push_frame($urandom_range(1, n));
        read_bins($urandom_range(1, n));
        push_frame($urandom_range(1, 2));
        read_bins($urandom_range(0, 2));
      end else begin
        push_frame(n);
        read_bins(n + $urandom_range(0, 2));
      end
    end

    // ---- size 15 clamps to the maximum: a partial frame, then no result
    write_reg(REG_INVERSE, 4'd0);
    write_reg(REG_SIZE_LOG2, 4'd15);
    push_frame(12);
    read_bins(2);
    // one larger inverse frame with part of its read-out
    write_reg(REG_INVERSE, 4'd1);
    write_reg(REG_SIZE_LOG2, 4'd8);
    push_frame(256);
    read_bins(40);

    // drain, then a short settle
    start_i <= 1'b0;
    @(posedge clk_i);
    while (bins_due != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("run covered %0d words, %0d full transforms, %0d bins checked",
             words_sent, frames_run, bins_seen);
    $display("sizes 2 to 256 points, forward and inverse, with abandoned frames");
    if (fail_count == 0 && bins_due == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
